FILE: src/csvu_pkg.sv
// ----------------------------------------------------------------------------
// csvu_pkg
// Types, character codes and helpers shared by the CSV line unquoter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvu_pkg;

	// Character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_C      = 8'h63;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Number of bytes an escaped comma expands to
	localparam logic [2:0] ESC_LEN = 3'd4;

	// Status codes reported at end of line
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_CLOSE = 2'd1,
		ST_STRAY    = 2'd2
	} status_t;

	// Parser modes, one-hot
	typedef enum logic [4:0] {
		MODE_START  = 5'b00001,
		MODE_PLAIN  = 5'b00010,
		MODE_QUOTED = 5'b00100,
		MODE_QPEND  = 5'b01000,
		MODE_DROP   = 5'b10000
	} mode_t;

	// Input request
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_line;
	} req_t;

	// Result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       status_valid;
		logic [1:0] status;
	} res_t;

	// Decision of the parser for one request
	typedef struct packed {
		mode_t      mode_nxt;
		logic [1:0] err_nxt;
		logic       eol;
		logic [2:0] cnt;
		logic       esc;
		logic [7:0] byte_v;
		logic       status_valid;
		logic [1:0] status;
	} parse_t;

	// Byte of the comma escape, by number of bytes still to send
	function automatic logic [7:0] esc_char(input logic [2:0] remaining);
		logic [7:0] c;
		unique case (remaining)
			3'd4:    c = CH_BSLASH;
			3'd3:    c = CH_X;
			3'd2:    c = CH_TWO;
			default: c = CH_C;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/csvu_parse.sv
// ----------------------------------------------------------------------------
// csvu_parse
// Per-character decision: next parser mode, error code and the result group
// (none, one byte, escaped comma or end-of-line status) for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module csvu_parse import csvu_pkg::*; (
	input  wire req_t       req,
	input  wire mode_t      mode,
	input  wire logic [1:0] err,
	output parse_t          dec
);

	logic [7:0] b;
	logic       is_quote;
	logic       is_comma;

	assign b        = req.in_byte;
	assign is_quote = (b == CH_QUOTE);
	assign is_comma = (b == CH_COMMA);

	// Decide mode and results for this character
	always_comb begin
		dec              = '0;
		dec.mode_nxt     = mode;
		dec.err_nxt      = err;
		dec.eol          = req.end_of_line || (b == CH_NUL);
		dec.byte_v       = b;
		if (dec.eol) begin
			// report status and return to field start
			dec.cnt          = 3'd1;
			dec.byte_v       = CH_NUL;
			dec.status_valid = 1'b1;
			dec.mode_nxt     = MODE_START;
			dec.err_nxt      = 2'd0;
			priority if (mode == MODE_DROP)
				dec.status = err;
			else if (mode == MODE_QUOTED)
				dec.status = ST_NO_CLOSE;
			else
				dec.status = ST_OK;
		end else begin
			unique case (mode)
				MODE_START: begin
					if (is_quote) begin
						dec.cnt      = 3'd0;
						dec.mode_nxt = MODE_QUOTED;
					end else begin
						dec.cnt      = 3'd1;
						dec.mode_nxt = is_comma ? MODE_START : MODE_PLAIN;
					end
				end
				MODE_PLAIN: begin
					dec.cnt = 3'd1;
					if (is_comma)
						dec.mode_nxt = MODE_START;
				end
				MODE_QUOTED: begin
					priority if (is_quote) begin
						dec.cnt      = 3'd0;
						dec.mode_nxt = MODE_QPEND;
					end else if (is_comma) begin
						dec.cnt = ESC_LEN;
						dec.esc = 1'b1;
					end else begin
						dec.cnt = 3'd1;
					end
				end
				MODE_QPEND: begin
					priority if (is_quote) begin
						dec.cnt      = 3'd1;
						dec.mode_nxt = MODE_QUOTED;
					end else if (is_comma) begin
						dec.cnt      = 3'd1;
						dec.mode_nxt = MODE_START;
					end else begin
						// stray character after closing quote
						dec.cnt      = 3'd0;
						dec.err_nxt  = ST_STRAY;
						dec.mode_nxt = MODE_DROP;
					end
				end
				MODE_DROP: begin
					dec.cnt = 3'd0;
				end
				default: begin
					// unknown code: behave as field start
					dec.cnt      = is_quote ? 3'd0 : 3'd1;
					dec.mode_nxt = is_quote ? MODE_QUOTED
						: (is_comma ? MODE_START : MODE_PLAIN);
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/csv_line_unquoter.sv
// ----------------------------------------------------------------------------
// csv_line_unquoter
// Unquotes one CSV line per sequence of requests and ends it with a status.
// ----------------------------------------------------------------------------
// Output: first result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while res_stall is low; a comma inside a
//   quoted field gives four results and holds the request side until the last
//   result leaves; the single result register drains one per unstalled cycle.
// Reset: parser returns to field start with no error, result register empty.
`default_nettype none

module csv_line_unquoter import csvu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	mode_t      mode_q;
	logic [1:0] err_q;
	logic [2:0] cnt_q;
	logic       esc_q;
	logic [7:0] byte_q;
	logic       stv_q;
	logic [1:0] st_q;
	parse_t     dec;
	logic       req_take;
	logic       res_take;

	csvu_parse u_parse (
		.req  (req),
		.mode (mode_q),
		.err  (err_q),
		.dec  (dec)
	);

	// Accept a request when the result register is empty or drains now
	assign res_take  = res_valid && !res_stall;
	assign req_stall = (cnt_q > 3'd1) || ((cnt_q == 3'd1) && res_stall);
	assign req_take  = req_valid && !req_stall;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			err_q  <= 2'd0;
		end else if (req_take) begin
			mode_q <= dec.mode_nxt;
			err_q  <= dec.err_nxt;
		end
	end

	// Result count: load a new group or count down as results leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (req_take) begin
			cnt_q <= dec.cnt;
		end else if (res_take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			esc_q  <= dec.esc;
			byte_q <= dec.byte_v;
			stv_q  <= dec.status_valid;
			st_q   <= dec.status;
		end
	end

	// Drive the current result
	assign res_valid        = (cnt_q != 3'd0);
	assign res.out_byte     = esc_q ? esc_char(cnt_q) : byte_q;
	assign res.last         = (cnt_q == 3'd1);
	assign res.status_valid = stv_q;
	assign res.status       = st_q;

	// An accepted end of line gives a status result in the next cycle
	a_eol_status: assert property (@(posedge clk) disable iff (!arst_n)
		(req_take && dec.eol) |=> (res_valid && res.status_valid && res.last))
		else $error("end of line did not produce a status result");

	// A status result carries no byte and closes its group
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status_valid) |-> (res.out_byte == CH_NUL && res.last))
		else $error("malformed status result");

	// An escape group continues until its last byte leaves
	a_esc_run: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && esc_q && (cnt_q > 3'd1)) |=>
			(res_valid && esc_q && (!req_take || res.last)))
		else $error("escape sequence broken");

endmodule

`default_nettype wire
